>>> hw/rtl/cdq_pkg.sv
// Shared types and codes for the circular deque.
package cdq_pkg;

    localparam int WORD_W = 32;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request codes
    localparam logic [1:0] MODE_ADD_FRONT = 2'd0;
    localparam logic [1:0] MODE_ADD_REAR  = 2'd1;
    localparam logic [1:0] MODE_REM_FRONT = 2'd2;
    localparam logic [1:0] MODE_REM_REAR  = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_EMPTY  = 2'd2;
    localparam logic [1:0] STAT_DENIED = 2'd3;

    // Restriction kinds
    localparam logic RESTR_OUTPUT = 1'b0;
    localparam logic RESTR_INPUT  = 1'b1;

    // Register indexes
    localparam logic REG_CAPACITY    = 1'b0;
    localparam logic REG_RESTRICTION = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              wr_en;
        logic [WORD_W-1:0] wdata;
    } t_cell_ctl;

endpackage

>>> hw/rtl/cdq_cell.sv
// One storage cell of the deque row: holds a slot and forwards the read word.
module cdq_cell #(
    parameter int SLOT_W   = 4,
    parameter int SLOT_IDX = 0
) (
    input  logic                        i_clk,
    input  cdq_pkg::t_cell_ctl          i_ctl,
    input  logic [SLOT_W-1:0]           i_wr_slot,
    input  logic [SLOT_W-1:0]           i_rd_slot,
    input  logic [cdq_pkg::WORD_W-1:0]  i_pass,
    output logic [cdq_pkg::WORD_W-1:0]  o_pass
);
    import cdq_pkg::*;

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(SLOT_IDX);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] r_pass;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && (i_wr_slot == MY_SLOT)) begin
            r_word <= i_ctl.wdata;
        end
        // take own word when addressed, else advance the neighbor's
        r_pass <= (i_rd_slot == MY_SLOT) ? r_word : i_pass;
    end

    assign o_pass = r_pass;

endmodule

>>> hw/rtl/cdq_ctrl.sv
// Deque control: head and tail indices, request decode, sequencing and result register.
module cdq_ctrl #(
    parameter int DEPTH  = 16,
    parameter int SLOT_W = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_mode,
    input  logic signed [cdq_pkg::WORD_W-1:0] i_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [cdq_pkg::WORD_W-1:0] o_removed_value,
    output logic [1:0]                        o_status,
    input  logic [cdq_pkg::CAP_W-1:0]         i_capacity,
    input  logic                              i_restriction,
    input  logic [cdq_pkg::WORD_W-1:0]        i_pass_last,
    output cdq_pkg::t_cell_ctl                o_cell_ctl,
    output logic [SLOT_W-1:0]                 o_wr_slot,
    output logic [SLOT_W-1:0]                 o_rd_slot
);
    import cdq_pkg::*;

    localparam int CMP_W = ((SLOT_W > CAP_W) ? SLOT_W : CAP_W) + 1;
    localparam logic [CMP_W-1:0]  DEPTH_C   = CMP_W'(DEPTH);
    localparam logic [SLOT_W-1:0] WALK_LAST = SLOT_W'(DEPTH - 1);

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_tail, n_tail;
    logic              r_empty, n_empty;
    logic [SLOT_W-1:0] r_rd_slot, n_rd_slot;
    logic [SLOT_W-1:0] r_cnt, n_cnt;
    logic [1:0]        r_status, n_status;
    logic              r_take, n_take;

    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  cap_eff;
    logic              accept;
    logic              denied;
    logic              full;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;

    function automatic logic [SLOT_W-1:0] step_up(input logic [SLOT_W-1:0] idx,
                                                   input logic [CMP_W-1:0]  cap);
        logic [CMP_W-1:0] nxt;
        nxt = CMP_W'(idx) + CMP_W'(1);
        return (nxt >= cap) ? '0 : nxt[SLOT_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] step_down(input logic [SLOT_W-1:0] idx,
                                                     input logic [CMP_W-1:0]  cap);
        logic [CMP_W-1:0] top;
        top = cap - CMP_W'(1);
        return (idx == '0) ? top[SLOT_W-1:0] : idx - SLOT_W'(1);
    endfunction

    // clamp capacity into 1..DEPTH
    always_comb begin
        cap_ext = CMP_W'(i_capacity);
        if (i_capacity == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_ext > DEPTH_C) begin
            cap_eff = DEPTH_C;
        end else begin
            cap_eff = cap_ext;
        end
    end

    assign accept = i_valid && (r_state == S_IDLE);
    assign denied = ((i_mode == MODE_ADD_FRONT) && (i_restriction == RESTR_INPUT)) ||
                    ((i_mode == MODE_REM_REAR) && (i_restriction == RESTR_OUTPUT));
    assign full   = !r_empty && (step_up(r_tail, cap_eff) == r_head);

    // request decode and index update
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_empty   = r_empty;
        n_rd_slot = r_rd_slot;
        n_status  = r_status;
        n_take    = r_take;
        n_cnt     = r_cnt;
        wr_en     = 1'b0;
        wr_slot   = '0;
        if (accept) begin
            n_status = STAT_DONE;
            n_take   = 1'b0;
            if (denied) begin
                n_status = STAT_DENIED;
            end else if ((i_mode == MODE_ADD_FRONT) || (i_mode == MODE_ADD_REAR)) begin
                if (full) begin
                    n_status = STAT_FULL;
                end else if (r_empty) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b0;
                    wr_en   = 1'b1;
                end else if (i_mode == MODE_ADD_FRONT) begin
                    n_head  = step_down(r_head, cap_eff);
                    wr_en   = 1'b1;
                    wr_slot = n_head;
                end else begin
                    n_tail  = step_up(r_tail, cap_eff);
                    wr_en   = 1'b1;
                    wr_slot = n_tail;
                end
            end else begin
                if (r_empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_take    = 1'b1;
                    n_cnt     = WALK_LAST;
                    n_rd_slot = (i_mode == MODE_REM_FRONT) ? r_head : r_tail;
                    if (r_head == r_tail) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_empty = 1'b1;
                    end else if (i_mode == MODE_REM_FRONT) begin
                        n_head = step_up(r_head, cap_eff);
                    end else begin
                        n_tail = step_down(r_tail, cap_eff);
                    end
                end
            end
        end else if ((r_state == S_WALK) && (r_cnt != '0)) begin
            n_cnt = r_cnt - SLOT_W'(1);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = n_take ? S_WALK : S_OUT;
                end
            end
            S_WALK: begin
                if (r_cnt == '0) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready          = (r_state == S_IDLE);
        o_valid          = (r_state == S_OUT);
        o_status         = r_status;
        o_removed_value  = r_take ? $signed(i_pass_last) : '0;
        o_cell_ctl.wr_en = wr_en;
        o_cell_ctl.wdata = i_value;
        o_wr_slot        = wr_slot;
        o_rd_slot        = r_rd_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_empty  <= 1'b1;
            r_cnt    <= '0;
            r_take   <= 1'b0;
            r_status <= STAT_DONE;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_empty  <= n_empty;
            r_cnt    <= n_cnt;
            r_take   <= n_take;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_slot <= n_rd_slot;
    end

endmodule

>>> hw/rtl/circular_deque.sv
// Top level of the circular deque: register port, control and the row of storage cells.
// Timing: an add, a refused request or a removal on an empty queue gives its result
//   in the cycle after acceptance; a successful removal gives it only after the read walk
//   through the cell row, one cell per cycle.
// Throughput: one word in flight; the next is accepted the cycle after the result is taken.
// Reset: indices zero, queue empty, capacity 16, output-restricted; stored words kept.
module circular_deque #(
    parameter int DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_mode,
    input  logic signed [cdq_pkg::WORD_W-1:0] i_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [cdq_pkg::WORD_W-1:0] o_removed_value,
    output logic [1:0]                        o_status,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import cdq_pkg::*;

    localparam int SLOT_W = $clog2(DEPTH);

    logic [CAP_W-1:0]  r_capacity;
    logic              r_restriction;
    logic              cfg_wr;
    logic              reg_idx;

    t_cell_ctl         cell_ctl;
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] rd_slot;
    logic [WORD_W-1:0] w_pass [DEPTH+1];

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity    <= CAP_RESET;
            r_restriction <= RESTR_OUTPUT;
        end else if (cfg_wr) begin
            if (reg_idx == REG_CAPACITY) begin
                r_capacity <= pwdata[CAP_W-1:0];
            end else begin
                r_restriction <= pwdata[0];
            end
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CAPACITY:    prdata = {{(32-CAP_W){1'b0}}, r_capacity};
            REG_RESTRICTION: prdata = {31'b0, r_restriction};
            default:         prdata = '0;
        endcase
    end

    cdq_ctrl #(
        .DEPTH  (DEPTH),
        .SLOT_W (SLOT_W)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_removed_value (o_removed_value),
        .o_status        (o_status),
        .i_capacity      (r_capacity),
        .i_restriction   (r_restriction),
        .i_pass_last     (w_pass[DEPTH]),
        .o_cell_ctl      (cell_ctl),
        .o_wr_slot       (wr_slot),
        .o_rd_slot       (rd_slot)
    );

    assign w_pass[0] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        cdq_cell #(
            .SLOT_W   (SLOT_W),
            .SLOT_IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (cell_ctl),
            .i_wr_slot (wr_slot),
            .i_rd_slot (rd_slot),
            .i_pass    (w_pass[g]),
            .o_pass    (w_pass[g+1])
        );
    end

endmodule

>>> hw/rtl/cdq_chk.sv
// Port-level checks for the circular deque, bound to the top level.
module cdq_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic signed [cdq_pkg::WORD_W-1:0] o_removed_value,
    input logic [1:0]                        o_status
);
    import cdq_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_removed_value) && $stable(o_status))
        else $error("result word changed while stalled");

    // one word in flight: never ready while a result is shown
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("ready while a result waits");

    // an accepted word makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("accepted a word while busy");

    // refused requests and full or empty reports return zero
    a_zero_on_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != STAT_DONE) |-> (o_removed_value == '0))
        else $error("nonzero word on refused request");

endmodule

bind circular_deque cdq_chk u_chk (.*);

>>> tb/sv/circular_deque_checker.sv
`timescale 1ns / 1ps
// Shadow deque for the circular deque: predicts each result and compares it at the output.
module circular_deque_checker #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [1:0]                 i_mode,
    input  logic [cdq_pkg::WORD_W-1:0] i_value,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [cdq_pkg::WORD_W-1:0] i_removed_value,
    input  logic [1:0]                 i_status,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [2:0]                 i_paddr,
    input  logic [31:0]                i_pwdata,
    input  logic                       i_pready,
    output int                         o_fail_count,
    output int                         o_outstanding
);
    import cdq_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [1:0]        status;
    } t_outcome;

    logic [WORD_W-1:0] slots [DEPTH];
    int                head_idx;
    int                tail_idx;
    logic              is_empty;
    logic [CAP_W-1:0]  cap_reg;
    logic              restr_reg;
    t_outcome          awaited_outcomes [$];
    int                fails = 0;
    int                waiting = 0;

    assign o_fail_count  = fails;
    assign o_outstanding = waiting;

    function automatic int next_up(input int idx, input int cap);
        return (idx + 1 >= cap) ? 0 : idx + 1;
    endfunction

    function automatic int next_down(input int idx, input int cap);
        return (idx == 0) ? cap - 1 : idx - 1;
    endfunction

    // Apply one request to the shadow deque and return the word and status it gives.
    function automatic t_outcome deque_apply(input logic [1:0] mode, input logic [WORD_W-1:0] word);
        t_outcome r;
        int       cap;
        int       slot;
        cap = (cap_reg == 0) ? 1 : (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
        r.word   = '0;
        r.status = STAT_DONE;
        if ((mode == MODE_ADD_FRONT && restr_reg == RESTR_INPUT) ||
            (mode == MODE_REM_REAR && restr_reg == RESTR_OUTPUT)) begin
            r.status = STAT_DENIED;
        end else if (mode == MODE_ADD_FRONT || mode == MODE_ADD_REAR) begin
            if (!is_empty && next_up(tail_idx, cap) == head_idx) begin
                r.status = STAT_FULL;
            end else if (is_empty) begin
                head_idx = 0;
                tail_idx = 0;
                is_empty = 1'b0;
                slots[0] = word;
            end else if (mode == MODE_ADD_FRONT) begin
                head_idx = next_down(head_idx, cap);
                slots[head_idx % DEPTH] = word;
            end else begin
                tail_idx = next_up(tail_idx, cap);
                slots[tail_idx % DEPTH] = word;
            end
        end else begin
            if (is_empty) begin
                r.status = STAT_EMPTY;
            end else begin
                slot   = (mode == MODE_REM_FRONT) ? head_idx : tail_idx;
                r.word = slots[slot % DEPTH];
                if (head_idx == tail_idx) begin
                    head_idx = 0;
                    tail_idx = 0;
                    is_empty = 1'b1;
                end else if (mode == MODE_REM_FRONT) begin
                    head_idx = next_up(head_idx, cap);
                end else begin
                    tail_idx = next_down(tail_idx, cap);
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_outcome want;
        if (!i_rst_n) begin
            head_idx  = 0;
            tail_idx  = 0;
            is_empty  = 1'b1;
            cap_reg   = CAP_RESET;
            restr_reg = RESTR_OUTPUT;
            awaited_outcomes.delete();
        end else begin
            // Check the outgoing word first: it can never belong to a request taken this edge.
            if (i_out_valid && i_out_ready) begin
                if (awaited_outcomes.size() == 0) begin
                    $display("%0t: result with nothing expected: word %h, status %0d",
                             $time, i_removed_value, i_status);
                    fails++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (i_removed_value !== want.word) begin
                        $display("%0t: removed word expected %h, got %h",
                                 $time, want.word, i_removed_value);
                        fails++;
                    end
                    if (i_status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, i_status);
                        fails++;
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == {REG_CAPACITY, 2'b00})
                    cap_reg = i_pwdata[CAP_W-1:0];
                else if (i_paddr == {REG_RESTRICTION, 2'b00})
                    restr_reg = i_pwdata[0];
            end
            if (i_in_valid && i_in_ready)
                awaited_outcomes.push_back(deque_apply(i_mode, i_value));
        end
        waiting = awaited_outcomes.size();
    end

endmodule

>>> tb/sv/tb_circular_deque.sv
`timescale 1ns / 1ps
// Testbench top for the circular deque: clock, reset, requests, register writes and verdict.
module tb_circular_deque;
    import cdq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int RUN_PHASES  = 16;
    localparam int PHASE_ITEMS = 90;

    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [1:0]               i_mode  = MODE_ADD_FRONT;
    logic signed [WORD_W-1:0] i_value = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic signed [WORD_W-1:0] o_removed_value;
    logic [1:0]               o_status;
    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [2:0]               paddr   = '0;
    logic [31:0]              pwdata  = '0;
    logic [31:0]              prdata;
    logic                     pready;

    int n_sent      = 0;
    int n_taken     = 0;
    int reg_writes  = 0;
    int idle_cycles = 0;
    int status_hits [4] = '{0, 0, 0, 0};
    int fail_count;
    int outstanding;
    bit quiet_tx = 1'b0;
    bit quiet_rx = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    circular_deque #(.DEPTH(DEPTH)) DUT (.*);

    circular_deque_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_mode          (i_mode),
        .i_value         (i_value),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_removed_value (o_removed_value),
        .i_status        (o_status),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    // Result side: stall a random number of cycles before taking each word.
    initial begin : result_sink
        int stall;
        forever begin
            stall = quiet_rx ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            n_taken               <= n_taken + 1;
            status_hits[o_status] <= status_hits[o_status] + 1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no traffic for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_word(input logic [1:0] mode, input logic [WORD_W-1:0] word);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_value <= word;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        n_sent++;
    endtask

    // Drop valid, wait for every result, then let the pipeline go quiet.
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        while (n_taken != n_sent) @(posedge i_clk);
        repeat (DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
    endtask

    // Unused upper bits carry noise; the register keeps only its own field.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        logic [31:0] data;
        data = $urandom();
        data[CAP_W-1:0] = cap;
        reg_write(REG_CAPACITY, data);
    endtask

    task automatic set_restriction(input logic kind);
        logic [31:0] data;
        data = $urandom();
        data[0] = kind;
        reg_write(REG_RESTRICTION, data);
    endtask

    initial begin : stimulus
        int          cap_sel;
        int          cap_eff;
        int          add_pct;
        logic [1:0]  mode;
        logic [31:0] word;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: capacity 16, rear removal refused.
        push_word(MODE_REM_FRONT, 32'h0000_0001);
        push_word(MODE_REM_REAR,  32'h0000_0002);
        push_word(MODE_ADD_FRONT, 32'h7FFF_FFFF);
        push_word(MODE_ADD_REAR,  32'h8000_0000);
        push_word(MODE_ADD_FRONT, 32'hFFFF_FFFF);
        push_word(MODE_ADD_REAR,  32'h0000_0000);
        push_word(MODE_REM_REAR,  32'hDEAD_BEEF);
        push_word(MODE_REM_FRONT, 32'h1234_5678);
        push_word(MODE_REM_FRONT, 32'h0);
        push_word(MODE_REM_FRONT, 32'h0);
        push_word(MODE_REM_FRONT, 32'h0);
        push_word(MODE_REM_FRONT, 32'h0);
        hold_until_drained();

        // Capacity zero acts as one; front add refused even on a full or empty deque.
        set_capacity(5'd0);
        set_restriction(RESTR_INPUT);
        push_word(MODE_ADD_REAR,  32'h1234_5678);
        push_word(MODE_ADD_REAR,  32'h5A5A_5A5A);
        push_word(MODE_ADD_FRONT, 32'hA5A5_A5A5);
        push_word(MODE_REM_REAR,  32'h0);
        push_word(MODE_REM_REAR,  32'h0);
        push_word(MODE_ADD_FRONT, 32'hC3C3_C3C3);
        hold_until_drained();

        // Capacity two: head wraps down from slot zero, then the deque fills.
        set_restriction(RESTR_OUTPUT);
        set_capacity(5'd2);
        push_word(MODE_ADD_FRONT, 32'h0F0F_0F0F);
        push_word(MODE_ADD_FRONT, 32'hF0F0_F0F0);
        push_word(MODE_ADD_REAR,  32'h3C3C_3C3C);
        push_word(MODE_REM_FRONT, 32'h0);
        push_word(MODE_REM_FRONT, 32'h0);

        for (int ph = 0; ph < RUN_PHASES; ph++) begin
            case (ph)
                0:       cap_sel = 1;
                1:       cap_sel = 16;
                2:       cap_sel = 31;
                3:       cap_sel = 0;
                4:       cap_sel = 2;
                5:       cap_sel = 17;
                default: cap_sel = $urandom_range(0, 31);
            endcase
            cap_eff = (cap_sel == 0) ? 1 : (cap_sel > DEPTH) ? DEPTH : cap_sel;
            hold_until_drained();
            set_capacity(cap_sel[CAP_W-1:0]);
            set_restriction(1'($urandom_range(0, 1)));
            quiet_tx = ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);
            add_pct  = $urandom_range(30, 70);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2) begin
                    // Hold the sender until every result is home; restriction may move here.
                    hold_until_drained();
                    if ($urandom_range(0, 1))
                        set_restriction(1'($urandom_range(0, 1)));
                end
                if ($urandom_range(0, 99) < add_pct)
                    mode = $urandom_range(0, 1) ? MODE_ADD_FRONT : MODE_ADD_REAR;
                else
                    mode = $urandom_range(0, 1) ? MODE_REM_FRONT : MODE_REM_REAR;
                case ($urandom_range(0, 7))
                    0:       word = 32'h8000_0000;
                    1:       word = 32'h7FFF_FFFF;
                    2:       word = 32'h0000_0000;
                    3:       word = 32'hFFFF_FFFF;
                    default: word = $urandom();
                endcase
                push_word(mode, word);
            end
            // Empty the deque before the capacity moves; front removal is never refused.
            repeat (cap_eff) push_word(MODE_REM_FRONT, $urandom());
        end

        hold_until_drained();
        $display("Covered %0d requests across %0d register writes and %0d phases",
                 n_sent, reg_writes, RUN_PHASES + 3);
        $display("Results: %0d done, %0d full, %0d empty, %0d refused; %0d still expected",
                 status_hits[STAT_DONE], status_hits[STAT_FULL], status_hits[STAT_EMPTY],
                 status_hits[STAT_DENIED], outstanding);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
